### sv/skcg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, beat control type and lookup values for the soft-knee gain computer.
// No dependencies; used by skcg_div.sv and soft_knee_compressor_gain.sv.
package skcg_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_INT_BITS  = 7;

  localparam int LOG_FRAC      = 16;   // fraction bits of log2 result
  localparam int MQ            = 30;   // mantissa / Horner fraction bits
  localparam int HORNER_TERMS  = 8;

  localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394566;     // 20*log10(2) in Q16
  localparam logic [29:0] LN2_Q30        = 30'd744261118;

  localparam logic [14:0] RATIO_MIN   = 15'd256;
  localparam logic [14:0] RATIO_MAX   = 15'd25600;
  localparam logic [14:0] RATIO_RESET = 15'd1024;
  localparam logic [4:0]  KNEE_RESET  = 5'd6;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE  = 8'd1;

  // floor(2^32 / j) for the Horner divide steps; j = 1 bypasses the table
  localparam logic [31:0] HORNER_RECIP [1:8] = '{
    32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'h4000_0000,
    32'h3333_3333, 32'h2AAA_AAAA, 32'h2492_4924, 32'h2000_0000
  };

  typedef struct packed {
    logic valid;
    logic unity;   // gain forced to 1.0
  } beat_ctl_t;

endpackage

### sv/skcg_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on skcg_pkg (beat_ctl_t).
module skcg_div #(
  parameter int NW = 58,
  parameter int DW = 37,
  parameter int QW = 25
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  skcg_pkg::beat_ctl_t      in_ctl,
  input  logic [NW-1:0]            in_num,
  input  logic [DW-1:0]            in_den,
  output skcg_pkg::beat_ctl_t      out_ctl,
  output logic [QW-1:0]            out_quo
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0]       rem [0:QW];
  logic [DW-1:0]       den [0:QW];
  logic [QW-1:0]       quo [0:QW];
  skcg_pkg::beat_ctl_t ctl [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= in_ctl;
    end
    if (en) begin
      rem[0] <= RW'(in_num);
      den[0] <= in_den;
      quo[0] <= '0;
    end
  end

  for (genvar gk = 1; gk <= QW; gk++) begin : g_bit
    localparam int B = QW - gk;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(den[gk-1]) << B;
    assign take = rem[gk-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[gk] <= '0;
      end else if (en) begin
        ctl[gk] <= ctl[gk-1];
      end
      if (en) begin
        rem[gk] <= take ? rem[gk-1] - dsh : rem[gk-1];
        den[gk] <= den[gk-1];
        quo[gk] <= quo[gk-1] | (QW'(take) << B);
      end
    end
  end

  assign out_ctl = ctl[QW];
  assign out_quo = quo[QW];

endmodule

### sv/soft_knee_compressor_gain.sv
`timescale 1ns / 1ps
// Top level of the soft-knee compressor gain computer: log2, dB knee law, exp2.
// Depends on skcg_pkg and skcg_div.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-------------------------------
//  s_*      | in        | s_tvalid / s_tready  | s_tdata: level (Q7.16)
//  m_*      | out       | m_tvalid / m_tready  | m_tdata: gain (Q1.16)
//  cfg_*    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One level per clock while the output is not stalled. The pipeline runs through
// the input register, the 16 squaring stages of log2 and the dB and knee
// stages, the bit-per-stage attenuation divider, a three-stage reciprocal multiply
// for the octave conversion and the 24 Horner stages of exp2 with the output
// register. Reset clears all valid bits and loads the register defaults.
// A stall on m_tready holds every stage in place; nothing drops.
module soft_knee_compressor_gain #(
  parameter int FRAC_BITS = skcg_pkg::DEF_FRAC_BITS,
  parameter int INT_BITS  = skcg_pkg::DEF_INT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [((INT_BITS+FRAC_BITS+7)/8)*8-1:0] s_tdata,   // [LW-1:0] level
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [((FRAC_BITS+1+7)/8)*8-1:0] m_tdata,          // [FRAC_BITS:0] gain
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [skcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [skcg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LW    = INT_BITS + FRAC_BITS;
  localparam int GW    = FRAC_BITS + 1;
  localparam int ODW   = ((GW + 7) / 8) * 8;
  localparam int PW    = $clog2(LW);
  localparam int EXPW  = PW + 1;
  localparam int LGW   = EXPW + skcg_pkg::LOG_FRAC;
  localparam int PRW   = LGW + 20;
  localparam int XW    = LGW + 3;
  localparam int SW    = 21;
  localparam int SQW   = 2 * SW;
  localparam int SELW  = (XW - 1 > SQW) ? XW - 1 : SQW;
  localparam int NW    = 15 + SELW + 1;
  localparam int DW    = 37;
  localparam int QW    = (XW > 21) ? XW : 21;
  localparam int AW    = QW - 1;
  localparam int N2W   = QW + 17;
  localparam int NNW   = AW - skcg_pkg::LOG_FRAC;
  localparam int MW    = skcg_pkg::MQ + 1;
  localparam int HST   = 3 * skcg_pkg::HORNER_TERMS;
  localparam int OCT_SH = 26;
  localparam int OPW   = QW + 1 + 24;

  localparam logic [MW-1:0] ONE_Q30 = MW'(1) << skcg_pkg::MQ;
  localparam logic [31:0]   ONE_OUT = 32'd1 << FRAC_BITS;
  localparam logic [23:0]   OCT_RECIP = 24'd11146542;   // floor(2^42 / 394566)

  // ---------------------------------------------------------------- config
  logic [14:0] ratio_q8;
  logic [4:0]  knee_width_db;
  logic [14:0] ratio_c;
  logic [14:0] ratio_m;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_q8      <= skcg_pkg::RATIO_RESET;
      knee_width_db <= skcg_pkg::KNEE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        skcg_pkg::REG_RATIO: ratio_q8      <= cfg_data[14:0];
        skcg_pkg::REG_KNEE:  knee_width_db <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp the ratio to 1.0 .. 100.0
  assign ratio_c = (ratio_q8 < skcg_pkg::RATIO_MIN) ? skcg_pkg::RATIO_MIN :
                   (ratio_q8 > skcg_pkg::RATIO_MAX) ? skcg_pkg::RATIO_MAX : ratio_q8;
  assign ratio_m = ratio_c - skcg_pkg::RATIO_MIN;

  // ------------------------------------------------------- pipeline enable
  // Every stage advances together; hold all of them while the output beat waits.
  logic en;
  assign en       = m_tready | ~m_tvalid;
  assign s_tready = en;

  // ------------------------------------------------------ input register
  logic [LW-1:0] lvl_r;
  logic          v_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (en) begin
      v_in <= s_tvalid;
    end
    if (en) begin
      lvl_r <= s_tdata[LW-1:0];
    end
  end

  // ------------------------------------- leading one and mantissa normalise
  logic [PW-1:0]    lod;
  logic [LW+29:0]   nrm;

  always_comb begin
    lod = '0;
    for (int i = 0; i < LW; i++) begin
      if (lvl_r[i]) begin
        lod = PW'(i);
      end
    end
  end

  assign nrm = {lvl_r, 30'b0} >> lod;

  // squaring chain: index 0 holds the normalised mantissa
  logic [MW-1:0]   sq_m [0:skcg_pkg::LOG_FRAC];
  logic [15:0]     sq_f [0:skcg_pkg::LOG_FRAC];
  logic [PW-1:0]   sq_p [0:skcg_pkg::LOG_FRAC];
  logic            sq_z [0:skcg_pkg::LOG_FRAC];
  logic            sq_v [0:skcg_pkg::LOG_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v_in;
    end
    if (en) begin
      sq_m[0] <= nrm[MW-1:0];
      sq_f[0] <= '0;
      sq_p[0] <= lod;
      sq_z[0] <= (lvl_r == '0);
    end
  end

  // Square the mantissa; a square of 2.0 or more yields a one bit and a halving.
  for (genvar gs = 1; gs <= skcg_pkg::LOG_FRAC; gs++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [31:0]     m2;
    assign sq = (2*MW)'(sq_m[gs-1]) * (2*MW)'(sq_m[gs-1]);
    assign m2 = sq[2*MW-1:skcg_pkg::MQ];

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[gs] <= 1'b0;
      end else if (en) begin
        sq_v[gs] <= sq_v[gs-1];
      end
      if (en) begin
        sq_m[gs] <= m2[31] ? m2[31:1] : m2[30:0];
        sq_f[gs] <= {sq_f[gs-1][14:0], m2[31]};
        sq_p[gs] <= sq_p[gs-1];
        sq_z[gs] <= sq_z[gs-1];
      end
    end
  end

  // ------------------------------------------------ log2 to dB (multiply)
  logic [EXPW-1:0]        lg_e;
  logic signed [LGW-1:0]  lg;
  logic signed [PRW-1:0]  lg_x;
  logic signed [PRW-1:0]  prod_r;
  logic                   prod_z;
  logic                   prod_v;

  assign lg_e = EXPW'(sq_p[skcg_pkg::LOG_FRAC]) - EXPW'(FRAC_BITS);
  assign lg   = $signed({lg_e, sq_f[skcg_pkg::LOG_FRAC]});
  assign lg_x = lg;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else if (en) begin
      prod_v <= sq_v[skcg_pkg::LOG_FRAC];
    end
    if (en) begin
      prod_r <= lg_x * $signed(PRW'(skcg_pkg::DB_PER_OCT_Q16));
      prod_z <= sq_z[skcg_pkg::LOG_FRAC];
    end
  end

  // ---------------------------------------- round to dB and classify region
  logic signed [PRW-1:0] prod_rnd;
  logic signed [XW-1:0]  xdb;
  logic signed [XW-1:0]  hk;
  logic signed [XW-1:0]  s_c;

  assign prod_rnd = prod_r + PRW'(32768);
  assign xdb      = $signed(prod_rnd[XW+15:16]);
  assign hk       = $signed(XW'({knee_width_db, 15'b0}));
  assign s_c      = xdb + hk;

  logic [SW-1:0]   cl_s;
  logic [XW-2:0]   cl_x;
  logic            cl_one;
  logic            cl_knee;
  logic            cl_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_v <= 1'b0;
    end else if (en) begin
      cl_v <= prod_v;
    end
    if (en) begin
      cl_s    <= s_c[SW-1:0];
      cl_x    <= xdb[XW-2:0];
      cl_one  <= prod_z | (xdb < -hk);
      cl_knee <= xdb < hk;
    end
  end

  // ---------------------------------------------- knee square and k*R
  logic [SQW-1:0] p1_ss;
  logic [XW-2:0]  p1_x;
  logic [19:0]    p1_kr;
  logic           p1_one;
  logic           p1_knee;
  logic           p1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= cl_v;
    end
    if (en) begin
      p1_ss   <= SQW'(cl_s) * SQW'(cl_s);
      p1_x    <= cl_x;
      p1_kr   <= 20'(knee_width_db) * 20'(ratio_c);
      p1_one  <= cl_one;
      p1_knee <= cl_knee;
    end
  end

  // --------------------------- attenuation in Q16 dB: (num + den/2) / den
  logic [SELW-1:0]      sel;
  logic [NW-1:0]        d1_num;
  logic [DW-1:0]        d1_den;
  skcg_pkg::beat_ctl_t  d1_in;
  skcg_pkg::beat_ctl_t  d1_out;
  logic [QW-1:0]        att;

  assign sel    = p1_knee ? SELW'(p1_ss) : SELW'(p1_x);
  assign d1_in  = '{valid: p1_v, unity: p1_one};

  always_comb begin
    if (p1_one) begin
      d1_num = '0;
      d1_den = DW'(1);
    end else if (p1_knee) begin
      d1_num = NW'(ratio_m) * NW'(sel) + NW'({p1_kr, 16'b0});
      d1_den = {p1_kr, 17'b0};
    end else begin
      d1_num = NW'(ratio_m) * NW'(sel) + NW'(ratio_c >> 1);
      d1_den = DW'(ratio_c);
    end
  end

  skcg_div #(.NW(NW), .DW(DW), .QW(QW)) u_att_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (d1_in),
    .in_num  (d1_num),
    .in_den  (d1_den),
    .out_ctl (d1_out),
    .out_quo (att)
  );

  // ------------------------------- dB to octaves: round(att*65536 / 394566)
  // Estimate the quotient from the top bits of the numerator times the reciprocal;
  // the estimate is exact or one short, so one compare of the remainder fixes it.
  logic [N2W-1:0]       d2_num;
  logic [OPW-1:0]       oc1_prod;
  logic [N2W-1:0]       oc1_num;
  skcg_pkg::beat_ctl_t  oc1_ctl;
  logic [AW-1:0]        oc2_q;
  logic [N2W-1:0]       oc2_qd;
  logic [N2W-1:0]       oc2_num;
  skcg_pkg::beat_ctl_t  oc2_ctl;
  logic [N2W-1:0]       oc_rem;
  skcg_pkg::beat_ctl_t  d2_out;
  logic [AW-1:0]        oct;

  assign d2_num = N2W'({att, 16'b0}) + N2W'(skcg_pkg::DB_PER_OCT_Q16 >> 1);
  assign oc_rem = oc2_num - oc2_qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      oc1_ctl <= '0;
      oc2_ctl <= '0;
      d2_out  <= '0;
    end else if (en) begin
      oc1_ctl <= d1_out;
      oc2_ctl <= oc1_ctl;
      d2_out  <= oc2_ctl;
    end
    if (en) begin
      oc1_prod <= OPW'(d2_num[N2W-1:skcg_pkg::LOG_FRAC]) * OPW'(OCT_RECIP);
      oc1_num  <= d2_num;
      oc2_q    <= oc1_prod[OPW-1:OCT_SH];
      oc2_qd   <= N2W'(oc1_prod[OPW-1:OCT_SH]) * N2W'(skcg_pkg::DB_PER_OCT_Q16);
      oc2_num  <= oc1_num;
      oct      <= (oc_rem >= N2W'(skcg_pkg::DB_PER_OCT_Q16)) ? oc2_q + AW'(1) : oc2_q;
    end
  end

  // ----------------------------------------------- exp2 of the fraction
  // Stage 0 forms t = f*ln2; then three stages per Horner term.
  skcg_pkg::beat_ctl_t ec  [0:HST];
  logic [NNW-1:0]      en_n[0:HST];
  logic [29:0]         tt  [0:HST-3];
  logic [45:0]         t_prod;

  assign t_prod = 46'(oct[15:0]) * 46'(skcg_pkg::LN2_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      ec[0] <= '0;
    end else if (en) begin
      ec[0] <= d2_out;
    end
    if (en) begin
      tt[0]   <= t_prod[45:16];
      en_n[0] <= oct[AW-1:16];
    end
  end

  for (genvar ge = 1; ge <= HST; ge++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rst) begin
        ec[ge] <= '0;
      end else if (en) begin
        ec[ge] <= ec[ge-1];
      end
      if (en) begin
        en_n[ge] <= en_n[ge-1];
      end
    end
    if (ge <= HST - 3) begin : g_t
      always_ff @(posedge clk) begin
        if (en) begin
          tt[ge] <= tt[ge-1];
        end
      end
    end
  end

  logic [MW-1:0] hp  [0:skcg_pkg::HORNER_TERMS];
  logic [29:0]   hx  [1:skcg_pkg::HORNER_TERMS];
  logic [29:0]   hxx [1:skcg_pkg::HORNER_TERMS];
  logic [29:0]   hq  [1:skcg_pkg::HORNER_TERMS];

  assign hp[0] = ONE_Q30;

  // p = 1 - ((t*p) >> 30) / j, for j from 8 down to 1
  for (genvar gh = 1; gh <= skcg_pkg::HORNER_TERMS; gh++) begin : g_horner
    localparam int J = skcg_pkg::HORNER_TERMS + 1 - gh;
    localparam logic [29:0] JV = 30'(J);
    logic [60:0] tp;
    logic [29:0] q0;
    logic [29:0] rr;
    logic [29:0] qc;

    assign tp = 61'(tt[3*gh-3]) * 61'(hp[gh-1]);

    if (J == 1) begin : g_unit
      assign q0 = hx[gh];
    end else begin : g_recip
      logic [61:0] qm;
      assign qm = 62'(hx[gh]) * 62'(skcg_pkg::HORNER_RECIP[J]);
      assign q0 = qm[61:32];
    end

    // reciprocal estimate is exact or one short: fix it with one compare
    assign rr = hxx[gh] - 30'(hq[gh] * JV);
    assign qc = (rr >= JV) ? hq[gh] + 30'd1 : hq[gh];

    always_ff @(posedge clk) begin
      if (en) begin
        hx[gh]  <= tp[59:30];
        hq[gh]  <= q0;
        hxx[gh] <= hx[gh];
        hp[gh]  <= ONE_Q30 - MW'(qc);
      end
    end
  end

  // ------------------------------------------ scale by 2^-n and round
  logic [NNW-1:0] nf;
  logic [4:0]     sh;
  logic [31:0]    g_rnd;
  logic [31:0]    g_lin;
  logic [GW-1:0]  gain_c;

  assign nf    = en_n[HST];
  assign sh    = 5'(30 - FRAC_BITS) + 5'(nf);
  assign g_rnd = (32'(hp[skcg_pkg::HORNER_TERMS]) + (32'd1 << (sh - 5'd1))) >> sh;

  always_comb begin
    if (nf > NNW'(FRAC_BITS + 1)) begin
      g_lin = '0;
    end else if (g_rnd > ONE_OUT) begin
      g_lin = ONE_OUT;
    end else begin
      g_lin = g_rnd;
    end
  end

  assign gain_c = ec[HST].unity ? GW'(ONE_OUT) : g_lin[GW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ec[HST].valid;
    end
    if (en) begin
      m_tdata <= ODW'(gain_c);
    end
  end

endmodule
